/* rtl/mcas_pkg.sv */
// Shared types, constants and the channel-to-motor map for the current scanner.
package mcas_pkg;

	localparam int unsigned GAIN_W   = 20;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned CFG_W    = 20;
	localparam int unsigned COUNT_W  = 14;
	localparam int unsigned PROD_W   = GAIN_W + COUNT_W;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned MA_W     = 19;
	localparam int unsigned N_MOTORS = 4;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd273067;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd8550;
	localparam logic [7:0]          CMD_BASE     = 8'h84;

	typedef enum logic [0:0] {
		REG_GAIN   = 1'b0,
		REG_OFFSET = 1'b1
	} cfg_reg_t;

	typedef logic [1:0] chan_t;
	typedef logic signed [MA_W-1:0] ma_t;

	// Board wiring: converter channel to motor slot.
	function automatic chan_t chan_to_motor(input chan_t ch);
		chan_t m;
		unique case (ch)
			2'd0: m = 2'd3;
			2'd1: m = 2'd0;
			2'd2: m = 2'd2;
			2'd3: m = 2'd1;
			default: m = 2'd0;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] cmd_for(input chan_t ch);
		return CMD_BASE | {1'b0, ch, 5'd0};
	endfunction

endpackage

/* rtl/motor_current_adc_scanner.sv */
// Motor current scanner: decodes converter reads, scales to mA, keeps four motor currents.
//
// Input channel (in_valid/in_ready): one completed three-byte converter read plus link_ok.
// Output channel (out_valid/out_ready): next conversion command byte, a sample_taken flag
// and the four stored motor currents (signed mA) as they stand after that read.
// A read with a good link and the ready bit (status_byte[7]) low is scaled as
// (gain_q16 * count) >> 16 - offset_ma, stored in the motor slot mapped from the active
// channel, and the channel advances round robin; any other read changes nothing.
// Result: the input register loads at the input accept, and the result register loads from it
// when the output is free. Throughput: one request per cycle while the result is not stalled;
// the path between the two registers is a single 20x14 multiply followed by one
// 19-bit subtract.
// The motor and channel registers double as the result register, so they are updated only
// when the result register is loaded.
// When out_ready is low the result holds and one more request is taken into the input
// register; in_ready then drops until the result is taken.
// Reset: gain and offset return to their calibration defaults, channel 0 is active, all
// currents read zero and both stages are empty.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 gain, 1 offset); write
// only while idle.
module motor_current_adc_scanner
	import mcas_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                link_ok,
	input  logic [7:0]          data_high,
	input  logic [7:0]          data_low,
	input  logic [7:0]          status_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          command_byte,
	output logic                sample_taken,
	output logic signed [MA_W-1:0] motor0_ma,
	output logic signed [MA_W-1:0] motor1_ma,
	output logic signed [MA_W-1:0] motor2_ma,
	output logic signed [MA_W-1:0] motor3_ma
);

	logic [GAIN_W-1:0]   gain_q;
	logic [OFFSET_W-1:0] offset_q;

	logic               valid_s1;
	logic               take_s1;
	logic [COUNT_W-1:0] count_s1;

	logic   out_valid_q;
	logic   taken_q;
	chan_t  chan_q;
	ma_t    motor_q [N_MOTORS];

	logic                       out_free;
	logic [PROD_W-1:0]          product;
	logic [PROD_W-FRAC_W-1:0]   scaled;
	logic [MA_W-1:0]            value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				REG_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			take_s1  <= link_ok && !status_byte[7];
			count_s1 <= {data_high[5:0], data_low};
		end
	end

	assign product = gain_q * {{(PROD_W-COUNT_W){1'b0}}, count_s1};
	assign scaled  = product[PROD_W-1:FRAC_W];
	// Wraps to two's complement when the offset exceeds the scaled value
	assign value   = {{(MA_W-(PROD_W-FRAC_W)){1'b0}}, scaled}
		- {{(MA_W-OFFSET_W){1'b0}}, offset_q};

	// Result register: flag, active channel and the motor currents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			taken_q     <= 1'b0;
			chan_q      <= '0;
			for (int i = 0; i < N_MOTORS; i++) begin
				motor_q[i] <= '0;
			end
		end else if (out_free) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				taken_q <= take_s1;
				if (take_s1) begin
					motor_q[chan_to_motor(chan_q)] <= ma_t'(value);
					chan_q <= chan_q + 2'd1;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_taken = taken_q;
	assign command_byte = cmd_for(chan_q);
	assign motor0_ma    = motor_q[0];
	assign motor1_ma    = motor_q[1];
	assign motor2_ma    = motor_q[2];
	assign motor3_ma    = motor_q[3];

endmodule

/* rtl/mcas_checker.sv */
// Port-level checks for the motor current scanner, bound to the top level.
module mcas_checker
	import mcas_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [7:0]             command_byte,
	input logic                   sample_taken,
	input logic signed [MA_W-1:0] motor0_ma
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command_byte)
			&& $stable(sample_taken) && $stable(motor0_ma))
		else $error("stalled result changed");

	// Every accepted request shows up as a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("request did not reach the output");

	// Back-pressure only comes from a stalled result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	// Command byte keeps its fixed one-shot bits
	a_cmd_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> command_byte[7] == 1'b1 && command_byte[4:0] == 5'h04)
		else $error("malformed command byte");

endmodule

bind motor_current_adc_scanner mcas_checker u_mcas_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.command_byte (command_byte),
	.sample_taken (sample_taken),
	.motor0_ma    (motor0_ma)
);

/* tb/sv/tb_motor_current_adc_scanner.sv */
// Self-checking testbench for the motor current scanner: directed and random reads, calibration changes, backpressure.
`timescale 1ns / 1ps

module tb_motor_current_adc_scanner;
	import mcas_pkg::*;

	localparam int HOLD_CYCLES = 60;
	localparam int SCAN_PHASES = 6;
	localparam int READS_PER_PHASE = 90;
	localparam chan_t MOTOR_OF_CHAN [N_MOTORS] = '{2'd3, 2'd0, 2'd2, 2'd1};

	typedef struct {
		logic       link;
		logic [7:0] high;
		logic [7:0] low;
		logic [7:0] status;
	} adc_read_t;

	typedef struct {
		logic [7:0] command;
		logic       taken;
		ma_t        motor [N_MOTORS];
	} scan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_GAIN;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic link_ok = 1'b0;
	logic [7:0] data_high = '0;
	logic [7:0] data_low = '0;
	logic [7:0] status_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] command_byte;
	logic sample_taken;
	ma_t motor0_ma, motor1_ma, motor2_ma, motor3_ma;

	// predicted scanner state
	logic [GAIN_W-1:0] mdl_gain;
	logic [OFFSET_W-1:0] mdl_offset;
	chan_t mdl_chan;
	ma_t mdl_ma [N_MOTORS];

	scan_result_t pending_scans [$];
	int errors = 0;

	// receiver pacing
	int rx_max_stall = 0;
	int hold_reqs = 0;
	int hold_done = 0;
	int tx_max_gap = 0;

	motor_current_adc_scanner u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.link_ok     (link_ok),
		.data_high   (data_high),
		.data_low    (data_low),
		.status_byte (status_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.command_byte(command_byte),
		.sample_taken(sample_taken),
		.motor0_ma   (motor0_ma),
		.motor1_ma   (motor1_ma),
		.motor2_ma   (motor2_ma),
		.motor3_ma   (motor3_ma)
	);

	always #1 clk = ~clk;

	initial begin
		#200000;
		$display("FAILED: results differ");
		$finish;
	end

	// Expected scanner outcome for one accepted read.
	function automatic void model_scan(input adc_read_t rd);
		logic [PROD_W-1:0] prod;
		logic [MA_W-1:0] ma;
		scan_result_t r;
		r.taken = rd.link && !rd.status[7];
		if (r.taken) begin
			prod = PROD_W'(mdl_gain) * PROD_W'({rd.high[5:0], rd.low});
			ma = MA_W'(prod[PROD_W-1:FRAC_W]) - MA_W'(mdl_offset);
			mdl_ma[MOTOR_OF_CHAN[mdl_chan]] = ma;
			mdl_chan = mdl_chan + 2'd1;
		end
		r.command = CMD_BASE | {1'b0, mdl_chan, 5'd0};
		r.motor = mdl_ma;
		pending_scans.push_back(r);
	endfunction

	function automatic adc_read_t random_read();
		adc_read_t rd;
		int pick;
		rd.link = ($urandom_range(0, 9) != 0);
		rd.high = 8'($urandom_range(0, 255));
		rd.low = 8'($urandom_range(0, 255));
		rd.status = 8'($urandom_range(0, 255));
		rd.status[7] = ($urandom_range(0, 99) < 15);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			rd.high[5:0] = 6'h3F;
			rd.low = 8'hFF;
		end else if (pick == 1) begin
			rd.high[5:0] = 6'h00;
			rd.low = 8'h00;
		end
		return rd;
	endfunction

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_read(input adc_read_t rd);
		logic took;
		in_valid <= 1'b1;
		link_ok <= rd.link;
		data_high <= rd.high;
		data_low <= rd.low;
		status_byte <= rd.status;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end
		model_scan(rd);
	endtask

	task automatic send_fields(input logic lk, input logic [7:0] hi, lo, st);
		adc_read_t rd;
		rd.link = lk;
		rd.high = hi;
		rd.low = lo;
		rd.status = st;
		send_read(rd);
	endtask

	// Drain everything in flight, then allow for the two-stage pipeline.
	task automatic go_idle();
		in_valid <= 1'b0;
		while (pending_scans.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Upper data bits on the offset write are don't-care, so they get noise.
	task automatic write_calibration(input logic [GAIN_W-1:0] gain,
			input logic [OFFSET_W-1:0] offset);
		cfg_we <= 1'b1;
		cfg_index <= REG_GAIN;
		cfg_data <= gain;
		@(posedge clk);
		cfg_index <= REG_OFFSET;
		cfg_data <= {4'($urandom_range(0, 15)), offset};
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_gain = gain;
		mdl_offset = offset;
	endtask

	// Receiver: random ready/stall runs, plus a long hold-off on request.
	always begin
		@(posedge clk);
		if (hold_reqs != hold_done) begin
			hold_done = hold_reqs;
			out_ready <= 1'b0;
			repeat (HOLD_CYCLES - 1) @(posedge clk);
		end else if (rx_max_stall == 0 || $urandom_range(0, 3) != 0) begin
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 7)) @(posedge clk);
		end else begin
			out_ready <= 1'b0;
			repeat ($urandom_range(0, rx_max_stall)) @(posedge clk);
		end
	end

	task automatic report_field(input string fname, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, fname, exp_v, got_v);
		end
	endtask

	// Result checker: sample before the edge, compare at the edge of acceptance.
	scan_result_t got;
	logic got_took;
	always begin
		scan_result_t exp_r;
		@(negedge clk);
		got_took = out_valid && out_ready;
		got.command = command_byte;
		got.taken = sample_taken;
		got.motor[0] = motor0_ma;
		got.motor[1] = motor1_ma;
		got.motor[2] = motor2_ma;
		got.motor[3] = motor3_ma;
		@(posedge clk);
		if (got_took === 1'b1) begin
			if (pending_scans.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got command %0h",
					$time, got.command);
			end else begin
				exp_r = pending_scans.pop_front();
				report_field("command_byte", exp_r.command, got.command);
				report_field("sample_taken", exp_r.taken, got.taken);
				for (int m = 0; m < N_MOTORS; m++)
					report_field($sformatf("motor%0d_ma", m), exp_r.motor[m], got.motor[m]);
			end
		end
	end

	// Default calibration: count extremes, ignored bits, link and ready failures.
	task automatic test_directed_reads();
		send_fields(1'b1, 8'h00, 8'h00, 8'h00);
		send_fields(1'b1, 8'h3F, 8'hFF, 8'h7F);
		send_fields(1'b1, 8'hFF, 8'hFF, 8'h00);
		send_fields(1'b1, 8'hC0, 8'h01, 8'h55);
		send_fields(1'b0, 8'h12, 8'h34, 8'h00);
		send_fields(1'b1, 8'h2A, 8'hAA, 8'h80);
		send_fields(1'b0, 8'hFF, 8'hFF, 8'hFF);
		send_fields(1'b1, 8'h80, 8'h00, 8'h80);
		send_fields(1'b1, 8'h15, 8'h55, 8'h00);
		send_fields(1'b1, 8'h2A, 8'hAA, 8'h7F);
		send_fields(1'b1, 8'h01, 8'h80, 8'h01);
		send_fields(1'b1, 8'h20, 8'h00, 8'h40);
		go_idle();
	endtask

	// Largest positive and most negative stored currents.
	task automatic test_calibration_extremes();
		write_calibration({GAIN_W{1'b1}}, '0);
		send_fields(1'b1, 8'h3F, 8'hFF, 8'h00);
		send_fields(1'b1, 8'h00, 8'h01, 8'h00);
		send_fields(1'b1, 8'hBF, 8'hFE, 8'h00);
		go_idle();
		write_calibration('0, {OFFSET_W{1'b1}});
		send_fields(1'b1, 8'h3F, 8'hFF, 8'h00);
		send_fields(1'b1, 8'h00, 8'h00, 8'h00);
		send_fields(1'b0, 8'h00, 8'h00, 8'h00);
		send_fields(1'b1, 8'h10, 8'h00, 8'h7F);
		go_idle();
	endtask

	// Receiver holds off long enough for the block to stall its input.
	task automatic test_output_backpressure();
		write_calibration(GAIN_RESET, OFFSET_RESET);
		rx_max_stall = 0;
		hold_reqs++;
		repeat (20) send_read(random_read());
		go_idle();
	endtask

	task automatic test_random_scan();
		logic [GAIN_W-1:0] gain;
		logic [OFFSET_W-1:0] offset;
		int sent;
		int burst;
		int gap;
		for (int p = 0; p < SCAN_PHASES; p++) begin
			case (p)
				0: begin
					gain = GAIN_RESET;
					offset = OFFSET_RESET;
				end
				1: begin
					gain = {GAIN_W{1'b1}};
					offset = '0;
				end
				2: begin
					gain = '0;
					offset = {OFFSET_W{1'b1}};
				end
				default: begin
					gain = GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
					offset = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
				end
			endcase
			write_calibration(gain, offset);
			rx_max_stall = (p % 3 == 0) ? 0 : 2 + 2 * p;
			tx_max_gap = (p % 2 == 0) ? 0 : 6;
			sent = 0;
			while (sent < READS_PER_PHASE) begin
				burst = $urandom_range(1, 16);
				for (int b = 0; b < burst && sent < READS_PER_PHASE; b++) begin
					send_read(random_read());
					sent++;
				end
				gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			go_idle();
		end
	endtask

	initial begin
		mdl_gain = GAIN_RESET;
		mdl_offset = OFFSET_RESET;
		mdl_chan = '0;
		for (int m = 0; m < N_MOTORS; m++)
			mdl_ma[m] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_reads();
		test_calibration_extremes();
		test_output_backpressure();
		test_random_scan();
		go_idle();
		repeat (4) @(posedge clk);
		if (errors == 0 && pending_scans.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
